[sv/pdqa_pkg.sv]
// Shared types, widths, codes and the micro-op program for the pose delta applier.
// No dependencies.
package pdqa_pkg;

   // datapath widths
   localparam int AccW  = 72;   // MAC accumulator, signed
   localparam int OpAW  = 36;   // multiplier operand A, signed
   localparam int OpBW  = 18;   // multiplier operand B, signed
   localparam int ProdW = OpAW + OpBW;
   localparam int MatW  = 35;   // rotation matrix entry, Q4.28
   localparam int RotW  = 43;   // rotated delta, Q16.16
   localparam int PW    = 34;   // quaternion product component, Q4.28
   localparam int NormW = 33;   // squared norm, unsigned
   localparam int NNW   = 66;   // product of the two squared norms
   localparam int RootW = 33;   // length of the product
   localparam int NumW  = 48;   // divider numerator
   localparam int QuoW  = 16;   // divider quotient
   localparam int SumW  = 57;   // translation plus scaled delta
   localparam int StepW = 7;

   localparam int SqrtTopBit = NNW - 2;
   localparam int RotShift   = 28;
   localparam int GainShift  = 16;

   localparam logic [StepW-1:0] LastStep = 7'd75;

   localparam logic signed [15:0] OneQ14 = 16'sd16384;
   localparam logic signed [SumW-1:0] SatMax = SumW'(64'sh7FFF_FFFF);
   localparam logic signed [SumW-1:0] SatMin = -SumW'(64'sh8000_0000);

   // configuration register indexes
   localparam logic CSR_GAIN = 1'b0;
   localparam logic CSR_FLIP = 1'b1;

   // operand A selects
   localparam logic [4:0] A_QX = 5'd0,  A_QY = 5'd1,  A_QZ = 5'd2,  A_QW = 5'd3;
   localparam logic [4:0] A_DX = 5'd4,  A_DY = 5'd5,  A_DZ = 5'd6,  A_DW = 5'd7;
   localparam logic [4:0] A_M0 = 5'd8,  A_M1 = 5'd9,  A_M2 = 5'd10, A_M3 = 5'd11;
   localparam logic [4:0] A_M4 = 5'd12, A_M5 = 5'd13, A_M6 = 5'd14, A_M7 = 5'd15;
   localparam logic [4:0] A_M8 = 5'd16, A_RLO = 5'd17, A_RHI = 5'd18, A_N1 = 5'd19;
   localparam int A_NUM = 20;

   // operand B selects
   localparam logic [4:0] B_QX = 5'd0,  B_QY = 5'd1,  B_QZ = 5'd2,  B_QW = 5'd3;
   localparam logic [4:0] B_DX = 5'd4,  B_DY = 5'd5,  B_DZ = 5'd6,  B_DW = 5'd7;
   localparam logic [4:0] B_VL0 = 5'd8, B_VL1 = 5'd9, B_VL2 = 5'd10;
   localparam logic [4:0] B_VH0 = 5'd11, B_VH1 = 5'd12, B_VH2 = 5'd13;
   localparam logic [4:0] B_GAIN = 5'd14, B_N2L = 5'd15, B_N2H = 5'd16;
   localparam int B_NUM = 17;

   // product shift
   localparam logic [1:0] SH_0 = 2'd0, SH_1 = 2'd1, SH_16 = 2'd2, SH_17 = 2'd3;

   // accumulator start value
   localparam logic [1:0] INIT_ZERO = 2'd0, INIT_RROT = 2'd1, INIT_RGAIN = 2'd2;

   localparam logic ADD = 1'b0;
   localparam logic SUB = 1'b1;

   // store destinations
   localparam logic [2:0] DST_M = 3'd0, DST_ROT = 3'd1, DST_TGT = 3'd2, DST_P = 3'd3;
   localparam logic [2:0] DST_N1 = 3'd4, DST_N2 = 3'd5, DST_NN = 3'd6;

   typedef struct packed {
      logic       mul;
      logic [4:0] a_sel;
      logic [4:0] b_sel;
      logic [1:0] shift;
      logic       neg;
      logic       first;
      logic       last;
      logic [2:0] dst;
      logic [3:0] idx;
      logic [1:0] init;
   } uop_type;

   typedef struct packed {
      logic       mul;
      logic [1:0] shift;
      logic       neg;
      logic       first;
      logic [1:0] init;
   } mac_ctl_type;

   function automatic uop_type u_op(input logic [4:0] a, input logic [4:0] b,
                                    input logic [1:0] sh, input logic ng,
                                    input logic fs, input logic ls,
                                    input logic [2:0] dst, input logic [3:0] idx,
                                    input logic [1:0] ini);
      uop_type u;
      u.mul   = 1'b1;
      u.a_sel = a;
      u.b_sel = b;
      u.shift = sh;
      u.neg   = ng;
      u.first = fs;
      u.last  = ls;
      u.dst   = dst;
      u.idx   = idx;
      u.init  = ini;
      return u;
   endfunction

   function automatic uop_type u_first(input logic [4:0] a, input logic [4:0] b,
                                       input logic [1:0] sh, input logic ng,
                                       input logic [1:0] ini);
      return u_op(a, b, sh, ng, 1'b1, 1'b0, DST_M, 4'd0, ini);
   endfunction

   function automatic uop_type u_mid(input logic [4:0] a, input logic [4:0] b,
                                     input logic [1:0] sh, input logic ng);
      return u_op(a, b, sh, ng, 1'b0, 1'b0, DST_M, 4'd0, INIT_ZERO);
   endfunction

   function automatic uop_type u_last(input logic [4:0] a, input logic [4:0] b,
                                      input logic [1:0] sh, input logic ng,
                                      input logic [2:0] dst, input logic [3:0] idx);
      return u_op(a, b, sh, ng, 1'b0, 1'b1, dst, idx, INIT_ZERO);
   endfunction

   // MAC program. A stored value is readable once it has passed the product and accumulator registers and been stored.
   function automatic uop_type uop_at(input logic [StepW-1:0] s);
      uop_type u;
      u = '0;
      case (s)
         // rotation matrix from the stored quaternion
         7'd0:  u = u_first(A_QW, B_QW, SH_0, ADD, INIT_ZERO);
         7'd1:  u = u_mid  (A_QX, B_QX, SH_0, ADD);
         7'd2:  u = u_mid  (A_QY, B_QY, SH_0, SUB);
         7'd3:  u = u_last (A_QZ, B_QZ, SH_0, SUB, DST_M, 4'd0);
         7'd4:  u = u_first(A_QX, B_QY, SH_1, ADD, INIT_ZERO);
         7'd5:  u = u_last (A_QW, B_QZ, SH_1, SUB, DST_M, 4'd1);
         7'd6:  u = u_first(A_QX, B_QZ, SH_1, ADD, INIT_ZERO);
         7'd7:  u = u_last (A_QW, B_QY, SH_1, ADD, DST_M, 4'd2);
         7'd8:  u = u_first(A_QX, B_QY, SH_1, ADD, INIT_ZERO);
         7'd9:  u = u_last (A_QW, B_QZ, SH_1, ADD, DST_M, 4'd3);
         7'd10: u = u_first(A_QW, B_QW, SH_0, ADD, INIT_ZERO);
         7'd11: u = u_mid  (A_QX, B_QX, SH_0, SUB);
         7'd12: u = u_mid  (A_QY, B_QY, SH_0, ADD);
         7'd13: u = u_last (A_QZ, B_QZ, SH_0, SUB, DST_M, 4'd4);
         7'd14: u = u_first(A_QY, B_QZ, SH_1, ADD, INIT_ZERO);
         7'd15: u = u_last (A_QW, B_QX, SH_1, SUB, DST_M, 4'd5);
         7'd16: u = u_first(A_QX, B_QZ, SH_1, ADD, INIT_ZERO);
         7'd17: u = u_last (A_QW, B_QY, SH_1, SUB, DST_M, 4'd6);
         7'd18: u = u_first(A_QY, B_QZ, SH_1, ADD, INIT_ZERO);
         7'd19: u = u_last (A_QW, B_QX, SH_1, ADD, DST_M, 4'd7);
         7'd20: u = u_first(A_QW, B_QW, SH_0, ADD, INIT_ZERO);
         7'd21: u = u_mid  (A_QX, B_QX, SH_0, SUB);
         7'd22: u = u_mid  (A_QY, B_QY, SH_0, SUB);
         7'd23: u = u_last (A_QZ, B_QZ, SH_0, ADD, DST_M, 4'd8);
         // quaternion product, stored times delta
         7'd24: u = u_first(A_QW, B_DX, SH_0, ADD, INIT_ZERO);
         7'd25: u = u_mid  (A_QX, B_DW, SH_0, ADD);
         7'd26: u = u_mid  (A_QY, B_DZ, SH_0, ADD);
         7'd27: u = u_last (A_QZ, B_DY, SH_0, SUB, DST_P, 4'd0);
         7'd28: u = u_first(A_QW, B_DY, SH_0, ADD, INIT_ZERO);
         7'd29: u = u_mid  (A_QY, B_DW, SH_0, ADD);
         7'd30: u = u_mid  (A_QZ, B_DX, SH_0, ADD);
         7'd31: u = u_last (A_QX, B_DZ, SH_0, SUB, DST_P, 4'd1);
         7'd32: u = u_first(A_QW, B_DZ, SH_0, ADD, INIT_ZERO);
         7'd33: u = u_mid  (A_QZ, B_DW, SH_0, ADD);
         7'd34: u = u_mid  (A_QX, B_DY, SH_0, ADD);
         7'd35: u = u_last (A_QY, B_DX, SH_0, SUB, DST_P, 4'd2);
         7'd36: u = u_first(A_QW, B_DW, SH_0, ADD, INIT_ZERO);
         7'd37: u = u_mid  (A_QX, B_DX, SH_0, SUB);
         7'd38: u = u_mid  (A_QY, B_DY, SH_0, SUB);
         7'd39: u = u_last (A_QZ, B_DZ, SH_0, SUB, DST_P, 4'd3);
         // row 0
         7'd40: u = u_first(A_M0, B_VH0, SH_16, ADD, INIT_RROT);
         7'd41: u = u_mid  (A_M0, B_VL0, SH_0, ADD);
         7'd42: u = u_mid  (A_M1, B_VH1, SH_16, ADD);
         7'd43: u = u_mid  (A_M1, B_VL1, SH_0, ADD);
         7'd44: u = u_mid  (A_M2, B_VH2, SH_16, ADD);
         7'd45: u = u_last (A_M2, B_VL2, SH_0, ADD, DST_ROT, 4'd0);
         // row 1
         7'd46: u = u_first(A_M3, B_VH0, SH_16, ADD, INIT_RROT);
         7'd47: u = u_mid  (A_M3, B_VL0, SH_0, ADD);
         7'd48: u = u_mid  (A_M4, B_VH1, SH_16, ADD);
         7'd49: u = u_mid  (A_M4, B_VL1, SH_0, ADD);
         7'd50: u = u_mid  (A_M5, B_VH2, SH_16, ADD);
         7'd51: u = u_last (A_M5, B_VL2, SH_0, ADD, DST_ROT, 4'd1);
         // gain on row 0, rotated value still holds row 0 here
         7'd52: u = u_first(A_RHI, B_GAIN, SH_17, ADD, INIT_RGAIN);
         7'd53: u = u_last (A_RLO, B_GAIN, SH_0, ADD, DST_TGT, 4'd0);
         // row 2, then gain on row 1
         7'd54: u = u_first(A_M6, B_VH0, SH_16, ADD, INIT_RROT);
         7'd55: u = u_mid  (A_M6, B_VL0, SH_0, ADD);
         7'd56: u = u_mid  (A_M7, B_VH1, SH_16, ADD);
         7'd57: u = u_mid  (A_M7, B_VL1, SH_0, ADD);
         7'd58: u = u_mid  (A_M8, B_VH2, SH_16, ADD);
         7'd59: u = u_last (A_M8, B_VL2, SH_0, ADD, DST_ROT, 4'd2);
         7'd60: u = u_first(A_RHI, B_GAIN, SH_17, ADD, INIT_RGAIN);
         7'd61: u = u_last (A_RLO, B_GAIN, SH_0, ADD, DST_TGT, 4'd1);
         // squared norms, then gain on row 2
         7'd62: u = u_first(A_QX, B_QX, SH_0, ADD, INIT_ZERO);
         7'd63: u = u_mid  (A_QY, B_QY, SH_0, ADD);
         7'd64: u = u_mid  (A_QZ, B_QZ, SH_0, ADD);
         7'd65: u = u_last (A_QW, B_QW, SH_0, ADD, DST_N1, 4'd0);
         7'd66: u = u_first(A_DX, B_DX, SH_0, ADD, INIT_ZERO);
         7'd67: u = u_mid  (A_DY, B_DY, SH_0, ADD);
         7'd68: u = u_mid  (A_DZ, B_DZ, SH_0, ADD);
         7'd69: u = u_last (A_DW, B_DW, SH_0, ADD, DST_N2, 4'd0);
         7'd70: u = u_first(A_RHI, B_GAIN, SH_17, ADD, INIT_RGAIN);
         7'd71: u = u_last (A_RLO, B_GAIN, SH_0, ADD, DST_TGT, 4'd2);
         // n1 * n2, two halves of n2
         7'd72: u = u_first(A_N1, B_N2L, SH_0, ADD, INIT_ZERO);
         7'd73: u = u_last (A_N1, B_N2H, SH_17, ADD, DST_NN, 4'd0);
         default: u = '0;
      endcase
      return u;
   endfunction

endpackage

[sv/pdqa_mac.sv]
// Shared multiply-accumulate unit: registered 36x18 signed multiplier feeding
// a 72-bit accumulator with shift, negate and preset. Depends on pdqa_pkg.
module pdqa_mac
   import pdqa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic signed [OpAW-1:0] op_a,
   input  logic signed [OpBW-1:0] op_b,
   input  mac_ctl_type            ctl,
   output logic signed [AccW-1:0] acc
);

   logic signed [ProdW-1:0] prod_ff, prod_in;
   mac_ctl_type             ctl_ff;
   logic signed [AccW-1:0]  acc_ff, acc_in;
   logic signed [AccW-1:0]  pext, term, base;

   assign prod_in = op_a * op_b;

   always_comb begin
      pext = AccW'(prod_ff);
      case (ctl_ff.shift)
         SH_0:    term = pext;
         SH_1:    term = pext <<< 1;
         SH_16:   term = pext <<< 16;
         SH_17:   term = pext <<< 17;
         default: term = pext;
      endcase
      if (ctl_ff.neg) begin
         term = -term;
      end
      case (ctl_ff.init)
         INIT_RROT:  base = AccW'(1) <<< (RotShift - 1);
         INIT_RGAIN: base = AccW'(1) <<< (GainShift - 1);
         default:    base = '0;
      endcase
      if (!ctl_ff.first) begin
         base = acc_ff;
      end
      acc_in = ctl_ff.mul ? base + term : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

[sv/pdqa_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
// Depends on pdqa_pkg.
module pdqa_isqrt
   import pdqa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NNW-1:0]   radicand,
   output logic             done,
   output logic [RootW-1:0] root
);

   logic [NNW-1:0] rem_ff, rem_in, r_ff, r_in, bit_ff, bit_in, trial;
   logic [5:0]     cnt_ff, cnt_in;
   logic           busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      trial   = r_ff + bit_ff;
      rem_in  = rem_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         r_in    = '0;
         bit_in  = NNW'(1) << SqrtTopBit;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            r_in   = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(RootW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign root = r_ff[RootW-1:0];

endmodule

[sv/pdqa_div.sv]
// Restoring divider, one quotient bit per cycle; quotient must
// stay below 2^16. Depends on pdqa_pkg.
module pdqa_div
   import pdqa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NumW-1:0]  num,
   input  logic [RootW-1:0] den,
   output logic             done,
   output logic [QuoW-1:0]  quo
);

   logic [NumW-1:0] rem_ff, rem_in, d_ff, d_in;
   logic [QuoW-1:0] q_ff, q_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         d_in    = NumW'(den) << (QuoW - 1);
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= d_ff) begin
            rem_in = rem_ff - d_ff;
            q_in   = {q_ff[QuoW-2:0], 1'b1};
         end else begin
            q_in = {q_ff[QuoW-2:0], 1'b0};
         end
         d_in   = d_ff >> 1;
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(QuoW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

[sv/pose_delta_quaternion_apply_core.sv]
// Pose delta applier top level: sequencer, pose state and output register.
// Depends on pdqa_pkg, pdqa_mac, pdqa_isqrt, pdqa_div.
//
//   channel  dir  handshake            contents
//   req_     in   req_valid/req_ready  op, delta or pose position and quaternion
//   rsp_     out  rsp_valid/rsp_ready  target position, unit quaternion, invalid
//   csr_     in   csr_we               delta_gain (index 0), flip_y (index 1)
//
// Load item (op 0): captured into the pose state on transfer. Apply item (op 1):
// 76 MAC steps on the shared multiplier, then a square root and four divides; when
// either quaternion is zero the root and divides are skipped. req_ready is high
// only when the sequencer is idle. A result waits in the output register; the
// next transfer is taken once the previous result has been handed on. Synchronous
// reset restores the identity pose, gain 0.5 and flip_y set.
module pose_delta_quaternion_apply_core
   import pdqa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic signed [31:0] req_in_pos_x,
   input  logic signed [31:0] req_in_pos_y,
   input  logic signed [31:0] req_in_pos_z,
   input  logic signed [15:0] req_in_rot_x,
   input  logic signed [15:0] req_in_rot_y,
   input  logic signed [15:0] req_in_rot_z,
   input  logic signed [15:0] req_in_rot_w,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_target_x,
   output logic signed [31:0] rsp_target_y,
   output logic signed [31:0] rsp_target_z,
   output logic signed [15:0] rsp_target_qx,
   output logic signed [15:0] rsp_target_qy,
   output logic signed [15:0] rsp_target_qz,
   output logic signed [15:0] rsp_target_qw,
   output logic               rsp_rotation_invalid,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [16:0]        csr_wdata
);

   typedef enum logic [2:0] {S_IDLE, S_MAC, S_ROOT, S_DIV, S_OUT} state_type;

   state_type              state_ff;
   logic [StepW-1:0]       step_ff;
   logic [1:0]             comp_ff;
   logic                   sq_start_ff, dv_start_ff;
   logic                   sq_start_in, dv_start_in;
   logic [16:0]            gain_ff;
   logic                   flip_ff;

   logic signed [31:0]     pt_ff [3];
   logic signed [15:0]     qs_ff [4];
   logic signed [15:0]     qd_ff [4];
   logic signed [32:0]     v_ff [3];
   logic signed [MatW-1:0] m_ff [9];
   logic signed [RotW-1:0] rot_ff;
   logic signed [31:0]     tgt_ff [3];
   logic signed [PW-1:0]   p_ff [4];
   logic [NormW-1:0]       n1_ff, n2_ff;
   logic [NNW-1:0]         nn_ff;
   logic signed [15:0]     qo_ff [4];
   logic                   inv_ff;

   logic                   l1_ff, st_ff;
   logic [2:0]             d1_ff, sd_ff;
   logic [3:0]             i1_ff, si_ff;

   logic                   rsp_valid_ff;
   logic signed [31:0]     rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic signed [15:0]     rsp_qx_ff, rsp_qy_ff, rsp_qz_ff, rsp_qw_ff;
   logic                   rsp_inv_ff;
   logic                   rsp_load;

   uop_type                u;
   logic signed [OpAW-1:0] a_opt [A_NUM];
   logic signed [OpBW-1:0] b_opt [B_NUM];
   logic signed [OpAW-1:0] op_a;
   logic signed [OpBW-1:0] op_b;
   mac_ctl_type            mac_ctl;
   logic signed [AccW-1:0] acc;
   logic signed [SumW-1:0] tsum;
   logic signed [31:0]     tsat;
   logic signed [32:0]     yext;
   logic signed [PW-1:0]   psel;
   logic [NormW-1:0]       pabs;
   logic [NumW-1:0]        dv_num;
   logic [RootW-1:0]       root;
   logic [QuoW-1:0]        dv_quo;
   logic                   sq_done, dv_done, invalid_now, req_xfer;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign yext      = 33'(req_in_pos_y);
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      u = uop_at(step_ff);
      for (int k = 0; k < 4; k++) begin
         a_opt[A_QX + k] = OpAW'(qs_ff[k]);
         a_opt[A_DX + k] = OpAW'(qd_ff[k]);
         b_opt[B_QX + k] = OpBW'(qs_ff[k]);
         b_opt[B_DX + k] = OpBW'(qd_ff[k]);
      end
      for (int k = 0; k < 9; k++) begin
         a_opt[A_M0 + k] = OpAW'(m_ff[k]);
      end
      a_opt[A_RLO] = OpAW'(rot_ff[16:0]);
      a_opt[A_RHI] = OpAW'($signed(rot_ff[RotW-1:17]));
      a_opt[A_N1]  = OpAW'(n1_ff);
      for (int k = 0; k < 3; k++) begin
         b_opt[B_VL0 + k] = OpBW'(v_ff[k][15:0]);
         b_opt[B_VH0 + k] = OpBW'($signed(v_ff[k][32:16]));
      end
      b_opt[B_GAIN] = OpBW'(gain_ff);
      b_opt[B_N2L]  = OpBW'(n2_ff[16:0]);
      b_opt[B_N2H]  = OpBW'(n2_ff[NormW-1:17]);
      op_a = (u.a_sel < 5'(A_NUM)) ? a_opt[u.a_sel] : '0;
      op_b = (u.b_sel < 5'(B_NUM)) ? b_opt[u.b_sel] : '0;

      mac_ctl.mul   = (state_ff == S_MAC) && u.mul;
      mac_ctl.shift = u.shift;
      mac_ctl.neg   = u.neg;
      mac_ctl.first = u.first;
      mac_ctl.init  = u.init;

      // target = pose + round(rot * gain), saturated
      tsum = SumW'($signed(acc[AccW-1:GainShift])) + SumW'(pt_ff[si_ff[1:0]]);
      if (tsum > SatMax) begin
         tsat = 32'sh7FFF_FFFF;
      end else if (tsum < SatMin) begin
         tsat = 32'sh8000_0000;
      end else begin
         tsat = tsum[31:0];
      end

      invalid_now = (n1_ff == '0) || (n2_ff == '0);
      psel   = p_ff[comp_ff];
      pabs   = psel[PW-1] ? NormW'(-psel) : NormW'(psel);
      dv_num = NumW'({pabs, 14'b0}) + NumW'(root[RootW-1:1]);

      sq_start_in = (state_ff == S_MAC) && (step_ff == LastStep) && !invalid_now;
      dv_start_in = ((state_ff == S_ROOT) && sq_done) ||
                    ((state_ff == S_DIV) && dv_done && (comp_ff != 2'd3));
   end

   pdqa_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op_a  (op_a),
      .op_b  (op_b),
      .ctl   (mac_ctl),
      .acc   (acc)
   );

   pdqa_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start_ff),
      .radicand (nn_ff),
      .done     (sq_done),
      .root     (root)
   );

   pdqa_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start_ff),
      .num   (dv_num),
      .den   (root),
      .done  (dv_done),
      .quo   (dv_quo)
   );

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         comp_ff      <= '0;
         sq_start_ff  <= 1'b0;
         dv_start_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sq_start_ff  <= sq_start_in;
         dv_start_ff  <= dv_start_in;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            S_IDLE: begin
               if (req_xfer && req_op) begin
                  step_ff  <= '0;
                  state_ff <= S_MAC;
               end
            end
            S_MAC: begin
               step_ff <= step_ff + 7'd1;
               if (step_ff == LastStep) begin
                  inv_ff <= invalid_now;
                  if (invalid_now) begin
                     for (int k = 0; k < 4; k++) begin
                        qo_ff[k] <= '0;
                     end
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_ROOT;
                  end
               end
            end
            S_ROOT: begin
               if (sq_done) begin
                  comp_ff  <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (dv_done) begin
                  qo_ff[comp_ff] <= psel[PW-1] ? -dv_quo : dv_quo;
                  if (comp_ff == 2'd3) begin
                     state_ff <= S_OUT;
                  end else begin
                     comp_ff <= comp_ff + 2'd1;
                  end
               end
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_x_ff     <= tgt_ff[0];
                  rsp_y_ff     <= tgt_ff[1];
                  rsp_z_ff     <= tgt_ff[2];
                  rsp_qx_ff    <= qo_ff[0];
                  rsp_qy_ff    <= qo_ff[1];
                  rsp_qz_ff    <= qo_ff[2];
                  rsp_qw_ff    <= qo_ff[3];
                  rsp_inv_ff   <= inv_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // pose state, configuration, item capture and MAC result stores
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 17'd32768;
         flip_ff <= 1'b1;
         for (int k = 0; k < 3; k++) begin
            pt_ff[k] <= '0;
         end
         for (int k = 0; k < 3; k++) begin
            qs_ff[k] <= '0;
         end
         qs_ff[3] <= OneQ14;
         l1_ff    <= 1'b0;
         st_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GAIN: gain_ff <= csr_wdata;
               CSR_FLIP: flip_ff <= csr_wdata[0];
               default:  gain_ff <= gain_ff;
            endcase
         end
         if (req_xfer && !req_op) begin
            pt_ff[0] <= req_in_pos_x;
            pt_ff[1] <= req_in_pos_y;
            pt_ff[2] <= req_in_pos_z;
            qs_ff[0] <= req_in_rot_x;
            qs_ff[1] <= req_in_rot_y;
            qs_ff[2] <= req_in_rot_z;
            qs_ff[3] <= req_in_rot_w;
         end
         l1_ff <= mac_ctl.mul && u.last;
         st_ff <= l1_ff;
      end
      d1_ff <= u.dst;
      i1_ff <= u.idx;
      sd_ff <= d1_ff;
      si_ff <= i1_ff;
      if (req_xfer && req_op) begin
         v_ff[0]  <= 33'(req_in_pos_x);
         v_ff[1]  <= flip_ff ? -yext : yext;
         v_ff[2]  <= 33'(req_in_pos_z);
         qd_ff[0] <= req_in_rot_x;
         qd_ff[1] <= req_in_rot_y;
         qd_ff[2] <= req_in_rot_z;
         qd_ff[3] <= req_in_rot_w;
      end
      if (st_ff) begin
         case (sd_ff)
            DST_M:   m_ff[si_ff]        <= acc[MatW-1:0];
            DST_ROT: rot_ff             <= acc[RotW+RotShift-1:RotShift];
            DST_TGT: tgt_ff[si_ff[1:0]] <= tsat;
            DST_P:   p_ff[si_ff[1:0]]   <= acc[PW-1:0];
            DST_N1:  n1_ff              <= acc[NormW-1:0];
            DST_N2:  n2_ff              <= acc[NormW-1:0];
            DST_NN:  nn_ff              <= acc[NNW-1:0];
            default: nn_ff              <= nn_ff;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_target_x         = rsp_x_ff;
   assign rsp_target_y         = rsp_y_ff;
   assign rsp_target_z         = rsp_z_ff;
   assign rsp_target_qx        = rsp_qx_ff;
   assign rsp_target_qy        = rsp_qy_ff;
   assign rsp_target_qz        = rsp_qz_ff;
   assign rsp_target_qw        = rsp_qw_ff;
   assign rsp_rotation_invalid = rsp_inv_ff;

endmodule
